/* rtl/ssd_pkg.sv */
// ----------------------------------------------------------------------------
// ssd_pkg
// Types, register codes and the segment patterns of the two-wire
// seven-segment display writer.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // Configuration channel widths
  localparam int unsigned CfgIndexW = 4;
  localparam int unsigned CfgDataW  = 16;

  // Register indexes of the configuration port
  typedef enum logic [CfgIndexW-1:0] {
    REG_MODE_COMMAND    = 4'd0,
    REG_ADDRESS_BASE    = 4'd1,
    REG_CONTROL_COMMAND = 4'd2,
    REG_HALF_PERIOD     = 4'd3
  } ssd_reg_e;

  // Reset values of the registers
  localparam logic [7:0]  ModeCommandRst    = 8'h44;
  localparam logic [7:0]  AddressBaseRst    = 8'hC0;
  localparam logic [7:0]  ControlCommandRst = 8'h8F;
  localparam logic [15:0] HalfPeriodRst     = 16'd100;

  // Input function codes
  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_LOAD = 1'b1
  } ssd_func_e;

  // Pin steps of a frame
  localparam logic [5:0] StartSteps   = 6'd3;
  localparam logic [5:0] ByteSteps    = 6'd28;
  localparam logic [5:0] ShortBody    = 6'd28;   // one byte
  localparam logic [5:0] LongBody     = 6'd56;   // address byte and segment byte
  localparam logic [5:0] ShortLen     = 6'd34;
  localparam logic [5:0] LongLen      = 6'd62;
  localparam logic [4:0] BitStepsEnd  = 5'd24;   // eight bits of three steps
  localparam logic [4:0] AckClkLow    = 5'd24;
  localparam logic [4:0] AckClkHigh   = 5'd25;
  localparam logic [4:0] AckDataLow   = 5'd26;

  localparam logic [7:0] DotBit = 8'h80;

  // Step within a bit (clock low, data, clock high) for each step of a byte
  localparam logic [1:0] BitPhase [32] = '{
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
    2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
    2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
  };

  // Payload of one input word
  typedef struct packed {
    logic       func;
    logic [7:0] digit_first;
    logic [7:0] digit_second;
    logic [7:0] digit_third;
    logic [7:0] digit_fourth;
  } ssd_in_t;

  // Payload of one result word
  typedef struct packed {
    logic clock_pin;
    logic data_pin;
    logic busy_res;
  } ssd_out_t;

  // Segment pattern of a digit index; anything above nine shows blank
  function automatic logic [6:0] seg_pattern(input logic [6:0] idx);
    logic [6:0] pat;
    unique case (idx)
      7'd0:    pat = 7'h3F;
      7'd1:    pat = 7'h06;
      7'd2:    pat = 7'h5B;
      7'd3:    pat = 7'h4F;
      7'd4:    pat = 7'h66;
      7'd5:    pat = 7'h6D;
      7'd6:    pat = 7'h7D;
      7'd7:    pat = 7'h07;
      7'd8:    pat = 7'h7F;
      7'd9:    pat = 7'h6F;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

endpackage

/* rtl/ssd_channels.sv */
// ----------------------------------------------------------------------------
// ssd_channels
// Valid/ready channels of the display writer: input words, result words and
// configuration writes.
// ----------------------------------------------------------------------------
interface ssd_in_if;
  import ssd_pkg::*;
  logic    valid;
  logic    ready;
  ssd_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ssd_out_if;
  import ssd_pkg::*;
  logic     valid;
  logic     ready;
  ssd_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ssd_cfg_if;
  import ssd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [CfgDataW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/seven_segment_two_wire_display_writer.sv */
// ----------------------------------------------------------------------------
// seven_segment_two_wire_display_writer
// Drives mode, address/segment and display-control frames on a two-wire
// clock/data link from load words, paced by tick words.
// ----------------------------------------------------------------------------
//
//  channel     dir  word                                   handshake
//  in_chan_i   in   func, four digit codes                 valid/ready
//  out_chan_o  out  clock_pin, data_pin, busy_res          valid/ready
//  cfg_chan_i  in   register index, write data             valid/ready
//
//  The sequencer step is short logic from the state registers into the result
//  register, so a word is taken each cycle while the output side drains.
//  A two-entry output stage (result register plus skid) lets one more word
//  in while a result waits; input ready falls only when both are full.
//  Reset puts both lines high, the sequencer idle and registers at defaults.
//  Configuration writes are always taken.
//
module seven_segment_two_wire_display_writer #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssd_in_if.sink    in_chan_i,
  ssd_out_if.source out_chan_o,
  ssd_cfg_if.sink   cfg_chan_i
);
  import ssd_pkg::*;

  localparam int unsigned DigIw = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [2:0]  LastDigit = 3'(DIGIT_COUNT);
  localparam logic [3:0]  LastFrame = 4'(DIGIT_COUNT + 1);

  // Configuration registers
  logic [7:0]  mode_cmd_q, addr_base_q, ctrl_cmd_q;
  logic [15:0] half_period_q;

  // Sequencer state
  logic [7:0]  digit_q [DIGIT_COUNT];
  logic [2:0]  frame_q, frame_d;
  logic [5:0]  phase_q, phase_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] hold_q, hold_d;
  logic        clk_line_q, clk_line_d;
  logic        dat_line_q, dat_line_d;
  logic        active_q, active_d;

  // Output stage
  logic     out_valid_q, skid_valid_q;
  ssd_out_t out_data_q, skid_data_q, result;

  logic        in_accept, out_pop;
  logic        apply_en, latch_en;
  logic [15:0] reload;
  logic [7:0]  din [4];

  logic        clk_a, dat_a;
  logic [7:0]  shift_a;

  function automatic logic is_digit(input logic [2:0] f);
    return (f != 3'd0) && (f <= LastDigit);
  endfunction

  assign in_accept = in_chan_i.valid && in_chan_i.ready;
  assign out_pop   = out_valid_q && out_chan_o.ready;
  assign in_chan_i.ready  = !skid_valid_q;
  assign cfg_chan_i.ready = 1'b1;

  assign din[0] = in_chan_i.data.digit_first;
  assign din[1] = in_chan_i.data.digit_second;
  assign din[2] = in_chan_i.data.digit_third;
  assign din[3] = in_chan_i.data.digit_fourth;

  // A zero half period holds for one tick
  assign reload = (half_period_q == 16'd0) ? 16'd1 : half_period_q;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_cmd_q    <= ModeCommandRst;
      addr_base_q   <= AddressBaseRst;
      ctrl_cmd_q    <= ControlCommandRst;
      half_period_q <= HalfPeriodRst;
    end else if (cfg_chan_i.valid) begin
      unique case (cfg_chan_i.index)
        REG_MODE_COMMAND:    mode_cmd_q    <= cfg_chan_i.data[7:0];
        REG_ADDRESS_BASE:    addr_base_q   <= cfg_chan_i.data[7:0];
        REG_CONTROL_COMMAND: ctrl_cmd_q    <= cfg_chan_i.data[7:0];
        REG_HALF_PERIOD:     half_period_q <= cfg_chan_i.data;
        default: ;  // unmapped index: drop the word
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: choose the next frame and phase, hold count and activity
  // --------------------------------------------------------------------------
  always_comb begin
    logic [5:0] phase_inc;
    logic [5:0] flen;
    logic [3:0] frame_inc;
    phase_inc = phase_q + 6'd1;
    flen      = is_digit(frame_q) ? LongLen : ShortLen;
    frame_inc = {1'b0, frame_q} + 4'd1;

    frame_d  = frame_q;
    phase_d  = phase_q;
    hold_d   = hold_q;
    active_d = active_q;
    apply_en = 1'b0;
    latch_en = 1'b0;

    if (in_chan_i.data.func == FUNC_LOAD) begin
      // A load while busy is dropped
      if (!active_q) begin
        latch_en = 1'b1;
        frame_d  = 3'd0;
        phase_d  = 6'd0;
        active_d = 1'b1;
        apply_en = 1'b1;
        hold_d   = reload;
      end
    end else if (active_q) begin
      if (hold_q > 16'd1) begin
        hold_d = hold_q - 16'd1;
      end else begin
        apply_en = 1'b1;
        hold_d   = reload;
        phase_d  = phase_inc;
        if (phase_inc >= flen) begin
          phase_d = 6'd0;
          if (frame_inc > LastFrame) begin
            // Sequence done: go idle, lines keep their levels
            frame_d  = 3'd0;
            active_d = 1'b0;
            hold_d   = 16'd0;
            apply_en = 1'b0;
          end else begin
            frame_d = frame_inc[2:0];
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pin step for the chosen frame and phase
  // --------------------------------------------------------------------------
  always_comb begin
    logic             dig;
    logic [5:0]       body;
    logic [5:0]       q;
    logic [5:0]       tail;
    logic             which;
    logic [4:0]       r;
    logic [2:0]       d_full;
    logic [DigIw-1:0] d;
    logic [7:0]       code;
    logic [7:0]       fbyte;

    dig    = is_digit(frame_d);
    body   = dig ? LongBody : ShortBody;
    q      = phase_d - StartSteps;
    tail   = phase_d - StartSteps - body;
    which  = (q >= ByteSteps);
    r      = which ? 5'(q - ByteSteps) : q[4:0];
    d_full = frame_d - 3'd1;
    d      = d_full[DigIw-1:0];
    code   = digit_q[d];

    // Byte of this frame: mode, address then segments, or control
    if (frame_d == 3'd0) begin
      fbyte = mode_cmd_q;
    end else if (dig) begin
      if (!which) begin
        fbyte = addr_base_q + 8'(d_full);
      end else begin
        fbyte = {code[7], seg_pattern(code[6:0])} | (code & DotBit);
      end
    end else begin
      fbyte = ctrl_cmd_q;
    end

    clk_a   = clk_line_q;
    dat_a   = dat_line_q;
    shift_a = shift_q;

    if (phase_d < StartSteps) begin
      // Start condition
      if (phase_d == 6'd0) begin
        clk_a = 1'b1;
      end else if (phase_d == 6'd1) begin
        dat_a = 1'b1;
      end else begin
        dat_a = 1'b0;
      end
    end else if (phase_d < StartSteps + body) begin
      if (r == 5'd0) begin
        shift_a = fbyte;
      end
      if (r < BitStepsEnd) begin
        unique case (BitPhase[r])
          2'd0: clk_a = 1'b0;
          2'd1: dat_a = shift_a[0];
          default: begin
            clk_a   = 1'b1;
            shift_a = {1'b0, shift_a[7:1]};
          end
        endcase
      end else if (r == AckClkLow) begin
        clk_a = 1'b0;
      end else if (r == AckClkHigh) begin
        clk_a = 1'b1;
      end else if (r == AckDataLow) begin
        dat_a = 1'b0;
      end else begin
        clk_a = 1'b0;
      end
    end else begin
      // Stop condition
      if (tail == 6'd0) begin
        dat_a = 1'b0;
      end else if (tail == 6'd1) begin
        clk_a = 1'b1;
      end else begin
        dat_a = 1'b1;
      end
    end
  end

  assign clk_line_d = apply_en ? clk_a : clk_line_q;
  assign dat_line_d = apply_en ? dat_a : dat_line_q;
  assign shift_d    = apply_en ? shift_a : shift_q;

  assign result.clock_pin = clk_line_d;
  assign result.data_pin  = dat_line_d;
  assign result.busy_res  = active_d;

  // --------------------------------------------------------------------------
  // State registers: advance on every accepted word
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q    <= 3'd0;
      phase_q    <= 6'd0;
      shift_q    <= 8'd0;
      hold_q     <= 16'd0;
      clk_line_q <= 1'b1;
      dat_line_q <= 1'b1;
      active_q   <= 1'b0;
    end else if (in_accept) begin
      frame_q    <= frame_d;
      phase_q    <= phase_d;
      shift_q    <= shift_d;
      hold_q     <= hold_d;
      clk_line_q <= clk_line_d;
      dat_line_q <= dat_line_d;
      active_q   <= active_d;
    end
  end

  // Latch the digit codes; digits past the fourth read as code zero
  for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_digit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        digit_q[i] <= 8'd0;
      end else if (in_accept && latch_en) begin
        digit_q[i] <= (i < 4) ? din[(i < 4) ? i : 0] : 8'd0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: result register with a skid entry behind it
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_accept;
        end
      end else if (in_accept) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_pop && skid_valid_q) begin
      out_data_q <= skid_data_q;
    end else if (in_accept && (out_pop || !out_valid_q)) begin
      out_data_q <= result;
    end
    if (in_accept && out_valid_q && !out_pop) begin
      skid_data_q <= result;
    end
  end

  assign out_chan_o.valid = out_valid_q;
  assign out_chan_o.data  = out_data_q;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full while result register empty");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && out_valid_q && !out_chan_o.ready) |=> skid_valid_q)
    else $error("word taken during a stall was not held in the skid entry");

  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (hold_q == 16'd0))
    else $error("hold count left running while idle");

  a_phase_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (phase_q < (is_digit(frame_q) ? LongLen : ShortLen)))
    else $error("phase beyond the end of its frame");

  a_frame_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, frame_q} <= LastFrame)
    else $error("frame index beyond the control frame");
`endif

endmodule

/* sim/seven_segment_two_wire_display_writer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seven_segment_two_wire_display_writer_tb
// Self-checking bench for the two-wire display writer. Input words (ticks and
// loads) go in through a bursty sender while the result side stalls on its
// own pattern. Each accepted word is run through a behavioural model of the
// frame sequencer; each result is checked in order against it or typed levels.
// ----------------------------------------------------------------------------
module seven_segment_two_wire_display_writer_tb;
  import ssd_pkg::*;

  // Bench timing and run size
  localparam int unsigned DigitCount    = 4;
  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned QuietLimit    = 2000;  // cycles with no handshake at all
  localparam int unsigned HoldOffCycles = 400;   // long result-side stall
  localparam int unsigned EndCycles     = 20;
  localparam int unsigned RandPhases    = 6;
  localparam int unsigned RandItems     = 450;
  localparam int unsigned ReportLimit   = 10;

  // Frame layout: start, bytes of 28 steps each, stop
  localparam int unsigned StartSteps  = 3;
  localparam int unsigned StopSteps   = 3;
  localparam int unsigned StepsOfByte = 28;
  localparam int unsigned BitSteps    = 24;  // eight bits of three steps each
  localparam int unsigned AckLowStep  = 24;
  localparam int unsigned AckHighStep = 25;
  localparam int unsigned AckDataStep = 26;
  localparam logic [6:0]  BlankIndex  = 7'd10;

  // Segment patterns for 0..9, then blank
  localparam logic [6:0] SegTable [11] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F, 7'h00
  };

  // What one row of the directed plan does
  typedef enum logic [1:0] {
    ROW_SEND,   // send the word reps times
    ROW_FLUSH,  // send ticks until the frame sequence has finished
    ROW_WRITE   // write a register once all results are in
  } plan_kind_e;

  typedef struct packed {
    plan_kind_e  kind;
    ssd_in_t     word;
    logic [15:0] reps;
    logic        check;   // compare against the typed levels below
    ssd_out_t    want;
    ssd_reg_e    reg_idx;
    logic [15:0] reg_val;
  } plan_row_t;

  localparam ssd_in_t  TickWord    = '{FUNC_TICK, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam ssd_out_t IdleHigh    = '{1'b1, 1'b1, 1'b0};
  localparam ssd_out_t BusyHigh    = '{1'b1, 1'b1, 1'b1};
  localparam ssd_out_t BusyDataLow = '{1'b1, 1'b0, 1'b1};
  localparam ssd_out_t NoLevels    = '{1'b0, 1'b0, 1'b0};

  // Directed plan: extremes of the digit codes, the blank and dot handling,
  // a load while busy, an idle tick, register extremes, a write while busy
  // and a zero half period.
  localparam plan_row_t DirectedPlan [22] = '{
    // idle tick: nothing moves, both lines stay high
    '{ROW_SEND, TickWord, 16'd1, 1'b1, IdleHigh, REG_MODE_COMMAND, 16'h0000},
    // load: clock driven high at once, busy rises
    '{ROW_SEND, '{FUNC_LOAD, 8'h00, 8'h7F, 8'h80, 8'hFF}, 16'd1, 1'b1, BusyHigh,
      REG_MODE_COMMAND, 16'h0000},
    // load while busy: dropped, lines unchanged
    '{ROW_SEND, '{FUNC_LOAD, 8'h01, 8'h02, 8'h03, 8'h04}, 16'd1, 1'b1, BusyHigh,
      REG_MODE_COMMAND, 16'h0000},
    // the default hold of 100 ticks: data high step, then data low step
    '{ROW_SEND, TickWord, 16'd99, 1'b1, BusyHigh, REG_MODE_COMMAND, 16'h0000},
    '{ROW_SEND, TickWord, 16'd100, 1'b1, BusyHigh, REG_MODE_COMMAND, 16'h0000},
    '{ROW_SEND, TickWord, 16'd1, 1'b1, BusyDataLow, REG_MODE_COMMAND, 16'h0000},
    // shortest hold from the next reload on, so the rest of the frames run quickly
    '{ROW_WRITE, TickWord, 16'd0, 1'b0, NoLevels, REG_HALF_PERIOD, 16'h0001},
    '{ROW_FLUSH, TickWord, 16'd0, 1'b0, NoLevels, REG_MODE_COMMAND, 16'h0000},
    // after the stop condition both lines rest high
    '{ROW_SEND, TickWord, 16'd1, 1'b1, IdleHigh, REG_MODE_COMMAND, 16'h0000},
    '{ROW_WRITE, TickWord, 16'd0, 1'b0, NoLevels, REG_MODE_COMMAND, 16'h00FF},
    '{ROW_WRITE, TickWord, 16'd0, 1'b0, NoLevels, REG_ADDRESS_BASE, 16'h00FE},
    '{ROW_WRITE, TickWord, 16'd0, 1'b0, NoLevels, REG_CONTROL_COMMAND, 16'h0000},
    // index ten, index eleven, dot on nine, blank index with dot
    '{ROW_SEND, '{FUNC_LOAD, 8'h0A, 8'h0B, 8'h89, 8'hE3}, 16'd1, 1'b0, NoLevels,
      REG_MODE_COMMAND, 16'h0000},
    '{ROW_FLUSH, TickWord, 16'd0, 1'b0, NoLevels, REG_MODE_COMMAND, 16'h0000},
    '{ROW_WRITE, TickWord, 16'd0, 1'b0, NoLevels, REG_MODE_COMMAND, 16'h0000},
    '{ROW_WRITE, TickWord, 16'd0, 1'b0, NoLevels, REG_ADDRESS_BASE, 16'h00FF},
    '{ROW_WRITE, TickWord, 16'd0, 1'b0, NoLevels, REG_CONTROL_COMMAND, 16'h00FF},
    '{ROW_SEND, '{FUNC_LOAD, 8'h05, 8'h86, 8'h07, 8'h88}, 16'd1, 1'b0, NoLevels,
      REG_MODE_COMMAND, 16'h0000},
    '{ROW_SEND, TickWord, 16'd5, 1'b0, NoLevels, REG_MODE_COMMAND, 16'h0000},
    // long hold, written mid-sequence: picked up at the next reload
    '{ROW_WRITE, TickWord, 16'd0, 1'b0, NoLevels, REG_HALF_PERIOD, 16'd48},
    '{ROW_SEND, TickWord, 16'd3, 1'b0, NoLevels, REG_MODE_COMMAND, 16'h0000},
    // zero half period counts as one tick once the long hold has run out
    '{ROW_WRITE, TickWord, 16'd0, 1'b0, NoLevels, REG_HALF_PERIOD, 16'h0000}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  ssd_in_if  in_if ();
  ssd_out_if out_if ();
  ssd_cfg_if cfg_if ();

  seven_segment_two_wire_display_writer #(
    .DIGIT_COUNT (DigitCount)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if),
    .out_chan_o (out_if),
    .cfg_chan_i (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Behavioural copy of the sequencer: registers, latched digits, frame and
  // step position, shift byte, hold counter and the two line levels.
  // --------------------------------------------------------------------------
  logic [7:0]  mode_cmd, addr_base, ctrl_cmd;
  logic [15:0] half_per;
  logic [7:0]  latch_q [DigitCount];
  int unsigned frame_no, step_no, hold_left;
  logic [7:0]  shifter;
  logic        clk_lvl, dat_lvl;
  bit          seq_busy;

  ssd_out_t    levels_due [$];   // line levels still to come out, oldest first
  int unsigned failures     = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;

  // Sender and receiver pacing
  int unsigned burst_left    = 0;
  int unsigned gap_max       = 6;
  bit          hold_off_req  = 1'b0;
  int unsigned stall_left    = 0;

  function automatic bit in_digit_frame();
    return frame_no >= 1 && frame_no <= DigitCount;
  endfunction

  function automatic int unsigned frame_steps();
    return StartSteps + StopSteps + StepsOfByte * (in_digit_frame() ? 2 : 1);
  endfunction

  // Byte sent in the current frame: address first, then segments, in a
  // digit frame; the mode or control command otherwise.
  function automatic logic [7:0] frame_payload(int unsigned which);
    logic [7:0] code;
    logic [6:0] idx;
    if (frame_no == 0) return mode_cmd;
    if (!in_digit_frame()) return ctrl_cmd;
    if (which == 0) return addr_base + 8'(frame_no - 1);
    code = latch_q[frame_no - 1];
    idx  = code[6:0];
    if (idx > BlankIndex) idx = BlankIndex;
    return {code[7], SegTable[idx]};
  endfunction

  function automatic void apply_pin_step();
    int unsigned body, q, r;
    body = frame_steps() - StartSteps - StopSteps;
    if (step_no < StartSteps) begin
      case (step_no)
        0:       clk_lvl = 1'b1;
        1:       dat_lvl = 1'b1;
        default: dat_lvl = 1'b0;
      endcase
    end else if (step_no < StartSteps + body) begin
      q = step_no - StartSteps;
      r = q % StepsOfByte;
      if (r == 0) shifter = frame_payload(q / StepsOfByte);
      if (r < BitSteps) begin
        case (r % 3)
          0:       clk_lvl = 1'b0;
          1:       dat_lvl = shifter[0];
          default: begin
            clk_lvl = 1'b1;
            shifter = shifter >> 1;
          end
        endcase
      end else begin
        case (r)
          AckLowStep:  clk_lvl = 1'b0;
          AckHighStep: clk_lvl = 1'b1;
          AckDataStep: dat_lvl = 1'b0;
          default:     clk_lvl = 1'b0;
        endcase
      end
    end else begin
      case (step_no - StartSteps - body)
        0:       dat_lvl = 1'b0;
        1:       clk_lvl = 1'b1;
        default: dat_lvl = 1'b1;
      endcase
    end
  endfunction

  function automatic int unsigned hold_reload();
    return (half_per == 16'd0) ? 1 : int'(half_per);
  endfunction

  function automatic void reset_predictor();
    foreach (latch_q[i]) latch_q[i] = 8'h00;
    frame_no  = 0;
    step_no   = 0;
    hold_left = 0;
    shifter   = 8'h00;
    clk_lvl   = 1'b1;
    dat_lvl   = 1'b1;
    seq_busy  = 1'b0;
    mode_cmd  = 8'h44;
    addr_base = 8'hC0;
    ctrl_cmd  = 8'h8F;
    half_per  = 16'd100;
  endfunction

  // Advance the sequencer by one input word and return the line levels
  function automatic ssd_out_t next_line_levels(ssd_in_t w);
    ssd_out_t lv;
    if (w.func == FUNC_LOAD) begin
      if (!seq_busy) begin
        latch_q[0] = w.digit_first;
        latch_q[1] = w.digit_second;
        latch_q[2] = w.digit_third;
        latch_q[3] = w.digit_fourth;
        frame_no   = 0;
        step_no    = 0;
        seq_busy   = 1'b1;
        apply_pin_step();
        hold_left  = hold_reload();
      end
    end else if (seq_busy) begin
      if (hold_left > 1) begin
        hold_left--;
      end else begin
        step_no++;
        if (step_no >= frame_steps()) begin
          step_no = 0;
          frame_no++;
          if (frame_no > DigitCount + 1) begin
            frame_no  = 0;
            seq_busy  = 1'b0;
            hold_left = 0;
          end
        end
        if (seq_busy) begin
          apply_pin_step();
          hold_left = hold_reload();
        end
      end
    end
    lv.clock_pin = clk_lvl;
    lv.data_pin  = dat_lvl;
    lv.busy_res  = seq_busy;
    return lv;
  endfunction

  // Digit code biased towards the table range, with the blank indexes and
  // the dot well represented
  function automatic logic [7:0] rand_digit();
    case ($urandom_range(0, 3))
      0, 1:    return {1'($urandom_range(0, 1)), 7'($urandom_range(0, 10))};
      2:       return 8'($urandom);
      default: return {1'($urandom_range(0, 1)), 7'($urandom_range(11, 127))};
    endcase
  endfunction

  function automatic ssd_in_t tick_word();
    ssd_in_t w;
    w = ssd_in_t'($urandom);
    w.func = FUNC_TICK;
    return w;
  endfunction

  // Mostly well-formed traffic: load when idle, tick while busy, with the
  // odd load while busy and the odd idle tick mixed in
  function automatic ssd_in_t random_word();
    ssd_in_t     w;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    w    = tick_word();
    if (seq_busy ? (roll < 3) : (roll < 70)) begin
      w.func         = FUNC_LOAD;
      w.digit_first  = rand_digit();
      w.digit_second = rand_digit();
      w.digit_third  = rand_digit();
      w.digit_fourth = rand_digit();
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: words go out in bursts of random length with random gaps between
  // them. Drive at the falling edge, take the handshake at the rising edge.
  // --------------------------------------------------------------------------
  task automatic send_word(input ssd_in_t w, input bit typed, input ssd_out_t want);
    int unsigned gap;
    ssd_out_t    lv;
    if (burst_left == 0) begin
      // no gaps while the receiver is holding off: keep the input pressed
      gap = (stall_left != 0) ? 0 : $urandom_range(0, gap_max);
      repeat (gap) begin
        @(negedge clk_i);
        in_if.valid = 1'b0;
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    @(negedge clk_i);
    in_if.valid = 1'b1;
    in_if.data  = w;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    lv = next_line_levels(w);
    levels_due.push_back(typed ? want : lv);
  endtask

  // Drop valid and hold until every expected result has come out
  task automatic pause_until_drained();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (levels_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input ssd_reg_e idx, input logic [15:0] val);
    pause_until_drained();
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_MODE_COMMAND:    mode_cmd  = val[7:0];
      REG_ADDRESS_BASE:    addr_base = val[7:0];
      REG_CONTROL_COMMAND: ctrl_cmd  = val[7:0];
      REG_HALF_PERIOD:     half_per  = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready follows a pattern that changes after a random run length
  // (always ready, coin toss, mostly stalled, mostly ready). On request it
  // holds off for a long stretch so that the output stage fills and the
  // input side stalls.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned ready_mode;
    int unsigned mode_left;
    ready_mode   = 0;
    mode_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HoldOffCycles;
      end
      if (stall_left != 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(32, 256);
        end
        mode_left--;
        case (ready_mode)
          0:       out_if.ready = 1'b1;
          1:       out_if.ready = 1'($urandom_range(0, 1));
          2:       out_if.ready = ($urandom_range(0, 4) == 0);
          default: out_if.ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every result word taken is compared with the oldest
  // expected levels. Report the first few failures in full, count the rest.
  // --------------------------------------------------------------------------
  ssd_out_t due_now;

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      results_seen++;
      if (levels_due.size() == 0) begin
        failures++;
        if (failures <= ReportLimit)
          $display("[%0t] result %0d arrived with nothing expected: clk=%b dio=%b busy=%b",
                   $time, results_seen, out_if.data.clock_pin, out_if.data.data_pin,
                   out_if.data.busy_res);
      end else begin
        due_now = levels_due.pop_front();
        if (out_if.data !== due_now) begin
          failures++;
          if (failures <= ReportLimit)
            $display("[%0t] result %0d: want clk=%b dio=%b busy=%b, got clk=%b dio=%b busy=%b",
                     $time, results_seen, due_now.clock_pin, due_now.data_pin,
                     due_now.busy_res, out_if.data.clock_pin, out_if.data.data_pin,
                     out_if.data.busy_res);
        end
      end
    end
  end

  // Watchdog: give up when no channel has moved a word for too long
  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t   row;
    int unsigned per_phase;
    logic [7:0]  mode_v, addr_v, ctrl_v;
    logic [15:0] hold_v;

    per_phase    = RandItems / RandPhases;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_MODE_COMMAND;
    cfg_if.data  = '0;
    reset_predictor();
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed plan; the typed levels stand in for the model where given
    foreach (DirectedPlan[i]) begin
      row = DirectedPlan[i];
      case (row.kind)
        ROW_SEND:  repeat (row.reps) send_word(row.word, row.check, row.want);
        ROW_FLUSH: while (seq_busy) send_word(tick_word(), 1'b0, NoLevels);
        default:   write_register(row.reg_idx, row.reg_val);
      endcase
    end
    // run out the long hold at the zero half period
    while (seq_busy) send_word(tick_word(), 1'b0, NoLevels);

    // Random phases, each with its own register setting. Keep the hold
    // short so that whole frame sequences fit; every third phase sends
    // without gaps.
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0: begin
          mode_v = 8'h00;
          addr_v = 8'h00;
          ctrl_v = 8'h00;
          hold_v = 16'd1;
        end
        1: begin
          mode_v = 8'hFF;
          addr_v = 8'hFF;
          ctrl_v = 8'hFF;
          hold_v = 16'd2;
        end
        default: begin
          mode_v = 8'($urandom);
          addr_v = 8'($urandom);
          ctrl_v = 8'($urandom);
          hold_v = 16'($urandom_range(1, 3));
        end
      endcase
      write_register(REG_MODE_COMMAND, {8'h00, mode_v});
      write_register(REG_ADDRESS_BASE, {8'h00, addr_v});
      write_register(REG_CONTROL_COMMAND, {8'h00, ctrl_v});
      write_register(REG_HALF_PERIOD, hold_v);
      gap_max = (ph % 3 == 2) ? 0 : $urandom_range(2, 12);

      for (int n = 0; n < per_phase; n++) begin
        // long result-side stall early in the second phase
        if (ph == 1 && n == 20) hold_off_req = 1'b1;
        // now and then let the whole pipeline drain before going on
        if ($urandom_range(0, 299) == 0) pause_until_drained();
        send_word(random_word(), 1'b0, NoLevels);
      end
    end

    pause_until_drained();
    repeat (EndCycles) @(posedge clk_i);
    if (levels_due.size() != 0) failures++;
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* seven_segment_two_wire_display_writer.f */
rtl/ssd_pkg.sv
rtl/ssd_channels.sv
rtl/seven_segment_two_wire_display_writer.sv
sim/seven_segment_two_wire_display_writer_tb.sv
